### src/ilse_pkg.sv
`default_nettype none

package ilse_pkg;

    // Number of cells in the chain, one stored end per cell
    localparam int CAPACITY = 64;

    // Field widths
    localparam int VAL_W = 30;
    localparam int LEN_W = 7;

    // Entry counter must be able to hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // What each cell shows to its right-hand neighbor every cycle.
    // ge_lo / ge_top treat an empty cell as "at or above", which keeps
    // both flags thermometer-coded along the chain.
    typedef struct packed {
        logic             valid;
        logic             ge_lo;
        logic             ge_top;
        logic [VAL_W-1:0] end_value;
    } ilse_link_t;

endpackage

`default_nettype wire

### src/interval_lis_sorted_ends_unit.sv
// The result is valid in the cycle after the input transfer.
// Throughput: 1 item per cycle unless a pending result is held by out_ready;
// all cells compare and shift in the same cycle, each cell looks only at its
// left neighbor, so the update path does not deepen with CAPACITY.
// Reset: asynchronous, active low; empties the list, clears the overflow flag
// and the output register. No clearing pass is needed.
`default_nettype none

module interval_lis_sorted_ends_unit
    import ilse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [VAL_W-1:0] low_bound,
    input  wire logic [VAL_W-1:0] high_bound,
    input  wire logic             restart,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [LEN_W-1:0]      lis_length,
    output logic                  overflowed
);

    ilse_link_t            links [CAPACITY+1];
    logic [CAPACITY-1:0]   grow_vec;
    logic                  load;
    logic                  drop_last;
    logic                  grow_any;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      count_base;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Handshake: a new transfer is taken unless a result is still pending and out_ready is low
    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Left boundary: acts as a full cell below every end
    assign links[0] = '{valid: 1'b1, ge_lo: 1'b0, ge_top: 1'b0, end_value: '0};

    // Chain of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        ilse_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (load),
            .restart    (restart),
            .low_bound  (low_bound),
            .high_bound (high_bound),
            .left_link  (links[g]),
            .right_link (links[g+1]),
            .grow       (grow_vec[g])
        );
    end

    // Length and overflow bookkeeping
    always_comb
    begin
        drop_last      = links[CAPACITY].valid && !links[CAPACITY].ge_top;
        grow_any       = |grow_vec;
        count_base     = restart ? '0 : count_reg;
        count_next     = count_base + CNT_W'(grow_any);
        ovf_next       = (ovf_reg && !restart) || drop_last;
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Result holds steady while pending since no transfer is taken then
    assign out_valid  = out_valid_reg;
    assign lis_length = LEN_W'(count_reg);
    assign overflowed = ovf_reg;

endmodule

`default_nettype wire

### src/ilse_cell.sv
`default_nettype none

module ilse_cell
    import ilse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic             restart,
    input  wire logic [VAL_W-1:0] low_bound,
    input  wire logic [VAL_W-1:0] high_bound,
    input  wire ilse_link_t       left_link,
    output ilse_link_t            right_link,
    output logic                  grow
);

    logic             valid_reg;
    logic             valid_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             eff_valid;
    logic             ge_lo;
    logic             ge_top;

    // Local compares; restart empties the cell for this transfer
    always_comb
    begin
        eff_valid = valid_reg && !restart;
        ge_lo     = !eff_valid || (value_reg >= low_bound);
        ge_top    = !eff_valid || ((value_reg >= low_bound) && (value_reg >= high_bound));
    end

    assign right_link = '{valid: eff_valid, ge_lo: ge_lo, ge_top: ge_top,
                           end_value: value_reg};

    // Next end: insert point takes low, bumped range shifts in from the left
    always_comb
    begin
        if (ge_lo && !left_link.ge_lo)
        begin
            value_next = low_bound;
        end
        else if (left_link.ge_lo && !left_link.ge_top)
        begin
            value_next = left_link.end_value + VAL_W'(1);
        end
        else
        begin
            value_next = value_reg;
        end
        valid_next = eff_valid || (left_link.valid && !left_link.ge_top);
        grow       = !eff_valid && left_link.valid && !left_link.ge_top;
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored end
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire
